FILE: design/i2p_pkg.sv
// Shared types and codes for the infix to postfix converter.
package i2p_pkg;

    // input token kinds
    localparam logic [2:0] CMD_OPERAND  = 3'd0;
    localparam logic [2:0] CMD_OPERATOR = 3'd1;
    localparam logic [2:0] CMD_LPAREN   = 3'd2;
    localparam logic [2:0] CMD_RPAREN   = 3'd3;
    localparam logic [2:0] CMD_END      = 3'd4;

    // stack entry: operator code 0..3, or left paren
    typedef logic [2:0] entry_t;
    localparam entry_t ENT_LPAREN = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_OPERAND  = 2'd0;
    localparam logic [1:0] KIND_OPERATOR = 2'd1;
    localparam logic [1:0] KIND_STATUS   = 2'd2;

    // status / error codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_MISMATCH = 2'd1;
    localparam logic [1:0] STAT_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  op;
        logic [31:0] value;
        logic [1:0]  status;
        logic        last;
    } result_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TOP,
        S_OPND,
        S_STAT
    } state_t;

    // true when the stacked operator must pop before the incoming one
    function automatic logic pops_before(input entry_t top, input logic [1:0] opc);
        return top[1] | ~opc[1];
    endfunction

endpackage

FILE: design/i2p_stack_ram.sv
// Operator stack storage: one write port, one registered read port.
module i2p_stack_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  i2p_pkg::entry_t      wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_W-1:0]    rd_addr,
    output i2p_pkg::entry_t      rd_data
);
    import i2p_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/i2p_out_reg.sv
// Output holding register for result transfers.
module i2p_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  i2p_pkg::result_t  load_item,
    output logic              free,
    output logic              out_valid,
    input  logic              out_ready,
    output i2p_pkg::result_t  item
);
    import i2p_pkg::*;

    logic    valid_reg;
    result_t item_reg;

    assign free = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= load_item;
        end
    end

    assign out_valid = valid_reg;
    assign item      = item_reg;

endmodule

FILE: design/infix_to_postfix_converter_top.sv
// Top level of the infix to postfix converter: token sequencer around the stack RAM.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-----------------------------------------
//   input    | in_valid / in_ready   | cmd, op_code, operand_value
//   output   | out_valid / out_ready | out_kind, out_op, out_value, status, last
//
// Operand: accepted, then loaded into the output register. Left paren: pushed on
// accept. Operator, right paren, end: accepted while the top is read, then each
// popped entry goes to the output register before the token finishes; the single
// read port sets the one-pop-per-cycle pace when not stalled. End adds a status item.
// Reset clears the state, stack count, error flag and pending flag; the RAM is not cleared.
// A full output register stalls the sequencer; the next token is taken when idle.
module infix_to_postfix_converter_top #(
    parameter int STACK_DEPTH  = 16,
    parameter int OPERAND_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  cmd,
    input  logic [1:0]  op_code,
    input  logic [31:0] operand_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  out_kind,
    output logic [1:0]  out_op,
    output logic [31:0] out_value,
    output logic [1:0]  status,
    output logic        last
);
    import i2p_pkg::*;

    localparam int IDX_W = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STACK_DEPTH);
    localparam logic [31:0] VALUE_MASK = (OPERAND_BITS >= 32) ? 32'hFFFF_FFFF :
                                         32'((64'd1 << OPERAND_BITS) - 64'd1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [1:0]       err_reg, err_next;
    logic             pend_vld_reg, pend_vld_next;
    logic [1:0]       pend_op_reg, pend_op_next;
    logic [2:0]       cmd_reg;
    logic [1:0]       opc_reg;
    logic [31:0]      val_reg;

    logic             accept;
    logic             wr_en, rd_en;
    logic [IDX_W-1:0] wr_addr, rd_addr;
    entry_t           wr_data, top;
    logic             load, free;
    result_t          load_item, out_item;

    logic [CNT_W-1:0] cnt_dec;
    logic             have_top, top_lp, pop, stall;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign cnt_dec  = count_reg - CNT_W'(1);
    assign have_top = (count_reg != '0);
    assign top_lp   = (top == ENT_LPAREN);
    assign stall    = pend_vld_reg && !free;

    always_comb
    begin
        case (cmd_reg)
            CMD_OPERATOR: pop = have_top && !top_lp && pops_before(top, opc_reg);
            default:      pop = have_top && !top_lp;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd == CMD_END && err_reg != STAT_OK)
                    begin
                        state_next = S_STAT;
                    end
                    else if (err_reg != STAT_OK)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (cmd == CMD_OPERAND)
                    begin
                        state_next = S_OPND;
                    end
                    else if (cmd inside {CMD_OPERATOR, CMD_RPAREN, CMD_END})
                    begin
                        state_next = S_TOP;
                    end
                end
            end
            S_TOP:
            begin
                if (!stall && !pop)
                begin
                    state_next = (cmd_reg == CMD_END) ? S_STAT : S_IDLE;
                end
            end
            S_OPND:
            begin
                if (free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_STAT:
            begin
                if (free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        count_next    = count_reg;
        err_next      = err_reg;
        pend_vld_next = pend_vld_reg;
        pend_op_next  = pend_op_reg;
        wr_en         = 1'b0;
        wr_addr       = count_reg[IDX_W-1:0];
        wr_data       = ENT_LPAREN;
        rd_en         = 1'b0;
        rd_addr       = cnt_dec[IDX_W-1:0];
        load          = 1'b0;
        load_item     = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && err_reg == STAT_OK)
                begin
                    if (cmd == CMD_LPAREN)
                    begin
                        if (count_reg >= DEPTH_C)
                        begin
                            err_next = STAT_OVERFLOW;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else if (cmd inside {CMD_OPERATOR, CMD_RPAREN, CMD_END})
                    begin
                        rd_en = have_top;
                    end
                end
            end
            S_TOP:
            begin
                rd_addr = IDX_W'(cnt_dec - CNT_W'(1));
                if (!stall)
                begin
                    if (pend_vld_reg)
                    begin
                        load           = 1'b1;
                        load_item.kind = KIND_OPERATOR;
                        load_item.op   = pend_op_reg;
                        load_item.last = !pop && (cmd_reg != CMD_END);
                    end
                    if (pop)
                    begin
                        pend_vld_next = 1'b1;
                        pend_op_next  = top[1:0];
                        count_next    = cnt_dec;
                        rd_en         = (cnt_dec != '0);
                    end
                    else
                    begin
                        pend_vld_next = 1'b0;
                        case (cmd_reg)
                            CMD_OPERATOR:
                            begin
                                if (count_reg >= DEPTH_C)
                                begin
                                    err_next = STAT_OVERFLOW;
                                end
                                else
                                begin
                                    wr_en      = 1'b1;
                                    wr_data    = {1'b0, opc_reg};
                                    count_next = count_reg + CNT_W'(1);
                                end
                            end
                            CMD_RPAREN:
                            begin
                                if (have_top)
                                begin
                                    count_next = cnt_dec;  // drop the matching paren
                                end
                                else
                                begin
                                    err_next = STAT_MISMATCH;
                                end
                            end
                            default:
                            begin
                                // end: a paren left on the stack is a mismatch
                                if (have_top)
                                begin
                                    err_next = STAT_MISMATCH;
                                end
                            end
                        endcase
                    end
                end
            end
            S_OPND:
            begin
                if (free)
                begin
                    load            = 1'b1;
                    load_item.kind  = KIND_OPERAND;
                    load_item.value = val_reg & VALUE_MASK;
                    load_item.last  = 1'b1;
                end
            end
            S_STAT:
            begin
                if (free)
                begin
                    load             = 1'b1;
                    load_item.kind   = KIND_STATUS;
                    load_item.status = err_reg;
                    load_item.last   = 1'b1;
                    count_next       = '0;
                    err_next         = STAT_OK;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            err_reg      <= STAT_OK;
            pend_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            err_reg      <= err_next;
            pend_vld_reg <= pend_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_op_reg <= pend_op_next;
        if (accept)
        begin
            cmd_reg <= cmd;
            opc_reg <= op_code;
            val_reg <= operand_value;
        end
    end

    i2p_stack_ram #(
        .DEPTH  (STACK_DEPTH),
        .ADDR_W (IDX_W)
    ) u_stack (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (top)
    );

    i2p_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .load_item (load_item),
        .free      (free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .item      (out_item)
    );

    assign out_kind  = out_item.kind;
    assign out_op    = out_item.op;
    assign out_value = out_item.value;
    assign status    = out_item.status;
    assign last      = out_item.last;

endmodule
